[src/in_order_completion_buffer_assert.svh]
// Assertion macros for the in-order completion buffer.
// Included by the top level; expects signals clk and rst in scope.
`ifndef IN_ORDER_COMPLETION_BUFFER_ASSERT_SVH
`define IN_ORDER_COMPLETION_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ioc_pkg.sv]
// Shared types and codes for the in-order completion buffer.
// Used by the cell and the top level; depends on nothing else.
package ioc_pkg;

  localparam logic CMD_ISSUE    = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  localparam logic [1:0] STATUS_RELEASED = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_DUP      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DRAIN = 3'b100
  } ioc_state_t;

  typedef struct packed {
    logic valid;
    logic done;
  } ioc_flags_t;

  typedef struct packed {
    logic load;
    logic mark;
    logic shift;
  } ioc_cell_ctl_t;

endpackage

[src/ioc_cell.sv]
// One entry of the buffer: tag, valid and done flags, and a tag comparator.
// Takes its neighbor's entry on a shift; uses types from ioc_pkg.
module ioc_cell #(
  parameter int TAG_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ioc_pkg::ioc_cell_ctl_t ctl,
  input  logic [TAG_BITS-1:0]  in_tag,
  input  ioc_pkg::ioc_flags_t  nbr_flags,
  input  logic [TAG_BITS-1:0]  nbr_tag,
  output ioc_pkg::ioc_flags_t  flags,
  output logic [TAG_BITS-1:0]  tag,
  output logic                 hit
);

  assign hit = flags.valid && (tag == in_tag);

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (ctl.shift) begin
      flags <= nbr_flags;
    end else if (ctl.load) begin
      flags.valid <= 1'b1;
      flags.done  <= 1'b0;
    end else if (ctl.mark && hit) begin
      flags.done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      tag <= nbr_tag;
    end else if (ctl.load) begin
      tag <= in_tag;
    end
  end

endmodule

[src/in_order_completion_buffer.sv]
// Top level of the in-order completion buffer: control, output register, cell row.
// Depends on ioc_pkg, ioc_cell and in_order_completion_buffer_assert.svh.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   command, tag
//   output   out        out_valid / out_stall out_tag, status, last
//
// An input word is accepted in the idle state, then its tag is compared in the check state.
// A completion that marks an entry then enters the drain state, which releases the done
// words at the head in order and returns to idle once no done word is left at the head.
// Every other item returns to idle from the check state. An output stall holds either in its state.
// Reset clears the valid and done flags of every cell and the entry count.
// A stalled output holds the word in its register; the row waits until it moves.
module in_order_completion_buffer #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [TAG_BITS-1:0] tag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [1:0]          status,
  output logic                last
);

  localparam int COUNT_W = $clog2(DEPTH + 1);

  ioc_pkg::ioc_state_t state, state_next;
  logic [COUNT_W-1:0]  count, count_next;
  logic                cmd_reg;
  logic [TAG_BITS-1:0] tag_reg;

  ioc_pkg::ioc_flags_t    cell_flags [DEPTH+1];
  logic [TAG_BITS-1:0]    cell_tag [DEPTH+1];
  ioc_pkg::ioc_cell_ctl_t cell_ctl [DEPTH];
  logic [DEPTH-1:0]       hit;
  logic [DEPTH-1:0]       done_vec;
  logic [DEPTH-1:0]       valid_vec;

  logic                load_now, mark_now, shift_now;
  logic                out_load, emit;
  logic [TAG_BITS-1:0] emit_tag;
  logic [1:0]          emit_status;
  logic                emit_last;
  logic                full, any_hit, outstanding, head_ready, more_ready;

  assign cell_flags[DEPTH] = '0;
  assign cell_tag[DEPTH]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctl[i].load  = load_now && (count == COUNT_W'(i));
    assign cell_ctl[i].mark  = mark_now;
    assign cell_ctl[i].shift = shift_now;
    assign done_vec[i]       = cell_flags[i].done;
    assign valid_vec[i]      = cell_flags[i].valid;

    ioc_cell #(.TAG_BITS(TAG_BITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl[i]),
      .in_tag    (tag_reg),
      .nbr_flags (cell_flags[i+1]),
      .nbr_tag   (cell_tag[i+1]),
      .flags     (cell_flags[i]),
      .tag       (cell_tag[i]),
      .hit       (hit[i])
    );
  end

  assign full        = (count == COUNT_W'(DEPTH));
  assign any_hit     = |hit;
  assign outstanding = |(hit & ~done_vec);
  assign head_ready  = cell_flags[0].valid && cell_flags[0].done;
  assign more_ready  = cell_flags[1].valid && cell_flags[1].done;
  assign out_load    = !out_valid || !out_stall;
  assign in_stall    = (state != ioc_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    load_now    = 1'b0;
    mark_now    = 1'b0;
    shift_now   = 1'b0;
    emit        = 1'b0;
    emit_tag    = tag_reg;
    emit_status = ioc_pkg::STATUS_RELEASED;
    emit_last   = 1'b1;
    case (state)
      ioc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ioc_pkg::ST_CHECK;
        end
      end
      ioc_pkg::ST_CHECK: begin
        if (cmd_reg == ioc_pkg::CMD_ISSUE) begin
          if (full || any_hit) begin
            emit_status = full ? ioc_pkg::STATUS_FULL : ioc_pkg::STATUS_DUP;
            if (out_load) begin
              emit       = 1'b1;
              state_next = ioc_pkg::ST_IDLE;
            end
          end else begin
            load_now   = 1'b1;
            count_next = count + COUNT_W'(1);
            state_next = ioc_pkg::ST_IDLE;
          end
        end else if (outstanding) begin
          mark_now   = 1'b1;
          state_next = ioc_pkg::ST_DRAIN;
        end else begin
          state_next = ioc_pkg::ST_IDLE;
        end
      end
      ioc_pkg::ST_DRAIN: begin
        emit_tag  = cell_tag[0];
        emit_last = !more_ready;
        if (!head_ready) begin
          state_next = ioc_pkg::ST_IDLE;
        end else if (out_load) begin
          emit       = 1'b1;
          shift_now  = 1'b1;
          count_next = count - COUNT_W'(1);
          if (!more_ready) begin
            state_next = ioc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ioc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ioc_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ioc_pkg::ST_IDLE && in_valid) begin
      cmd_reg <= command;
      tag_reg <= tag;
    end
    if (emit) begin
      out_tag <= emit_tag;
      status  <= emit_status;
      last    <= emit_last;
    end
  end

`include "in_order_completion_buffer_assert.svh"

  `IOC_ASSERT_NOW(a_count_matches_cells, 1'b1,
    $countones(valid_vec) == int'(count), "Entry count disagrees with valid cells.")
  `IOC_ASSERT_NOW(a_release_from_drain,
    $rose(out_valid) && status == ioc_pkg::STATUS_RELEASED,
    $past(state) == ioc_pkg::ST_DRAIN, "Released word did not come from the drain.")
  `IOC_ASSERT_NEXT(a_shift_frees_one, shift_now,
    count == $past(count) - COUNT_W'(1), "Shift did not free exactly one entry.")

endmodule
